// File: rtl/dgsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgsp_pkg: shared types and constants of the dense graph shortest path block
// Sequencer state encoding, request codes and fixed field limits.
// ----------------------------------------------------------------------------
package dgsp_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Width and saturation limit of the reported path cost.
  localparam int unsigned        OUT_COST_W    = 22;
  localparam logic [21:0]        COST_OUT_MAX  = 22'h3FFFFF;

  // Node count register width and reset value.
  localparam int unsigned        NODE_CNT_W    = 7;
  localparam logic [6:0]         NODE_CNT_RST  = 7'd64;

  typedef enum logic [3:0] {
    ST_CLEAR,   // sweeping the edge matrix after reset
    ST_IDLE,    // waiting for a transaction
    ST_INIT,    // seeding the source node
    ST_RELAX,   // streaming one row of the matrix
    ST_RWAIT,   // finishing the last element of the row
    ST_NEXT,    // settling the next node or ending the search
    ST_COST,    // reading the destination cost
    ST_COST2,   // loading the first result
    ST_EMIT,    // result waiting on the output
    ST_PRED     // predecessor read in flight
  } state_t;

endpackage

// File: rtl/dense_graph_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_graph_shortest_path: Dijkstra search over a dense edge matrix
// Holds directed edge costs for up to MAX_NODES nodes, runs the search on a
// query and streams the path from the destination back to the source.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------------
//  in_     | input     | in_valid/in_stall  | req_type, from/to node, weight, present
//  out_    | output    | out_valid/out_stall| path_node, total_cost, reachable, last
//  cfg_    | input     | cfg_valid/cfg_ready| node_count (7 bits)
//
//  A query runs the search as one pass through a matrix row per settled node
//  over the single edge memory read port, then reports the path node by node.
//  After reset a clearing pass over all MAX_NODES*MAX_NODES entries empties
//  the edge matrix; in_stall stays high meanwhile while configuration writes
//  are taken. While a query is searched or its results are pending, in_stall
//  is high. A stalled result holds its payload until the transaction
//  completes.
//
module dense_graph_shortest_path
  import dgsp_pkg::*;
#(
  parameter int MAX_NODES  = 64,
  parameter int COST_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [5:0]  in_from_node,
  input  logic [5:0]  in_to_node,
  input  logic [15:0] in_edge_weight,
  input  logic        in_edge_present,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_path_node,
  output logic [21:0] out_total_cost,
  output logic        out_reachable,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  // Best costs need room for a path through every node.
  localparam int BW    = COST_WIDTH + NW;
  localparam int XW    = (BW > OUT_COST_W) ? BW : OUT_COST_W;

  // --------------------------------------------------------------------------
  // Memories. The edge matrix keeps a valid bit above the cost of each entry.
  // --------------------------------------------------------------------------
  logic [COST_WIDTH:0] edge_mem [DEPTH];
  logic [BW-1:0]       best_mem [MAX_NODES];
  logic [NW-1:0]       pred_mem [MAX_NODES];

  logic [COST_WIDTH:0] edge_q;
  logic [BW-1:0]       best_q;
  logic [NW-1:0]       pred_q;

  logic                edge_we;
  logic [AW-1:0]       edge_waddr;
  logic [COST_WIDTH:0] edge_wdata;
  logic [AW-1:0]       edge_raddr;
  logic                best_we;
  logic [NW-1:0]       best_waddr;
  logic [BW-1:0]       best_wdata;
  logic [NW-1:0]       best_raddr;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic [NODE_CNT_W-1:0] node_cnt_r;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [NW-1:0]         src_r, src_nxt;
  logic [NW-1:0]         dst_r, dst_nxt;
  logic [NW-1:0]         p_r, p_nxt;          // node being settled
  logic [BW-1:0]         bp_r, bp_nxt;        // its cost
  logic [NW-1:0]         idx_r, idx_nxt;      // row element being issued
  logic                  s2_vld_r, s2_vld_nxt;
  logic [NW-1:0]         s2_idx_r, s2_idx_nxt;
  logic                  min_found_r, min_found_nxt;
  logic [NW-1:0]         min_idx_r, min_idx_nxt;
  logic [BW-1:0]         min_cost_r, min_cost_nxt;
  logic [MAX_NODES-1:0]  reached_r, reached_nxt;
  logic [MAX_NODES-1:0]  settled_r, settled_nxt;
  logic [NW-1:0]         hops_r, hops_nxt;
  logic [5:0]            o_node_r, o_node_nxt;
  logic [21:0]           o_cost_r, o_cost_nxt;
  logic                  o_reach_r, o_reach_nxt;
  logic                  o_last_r, o_last_nxt;

  // --------------------------------------------------------------------------
  // Derived values
  // --------------------------------------------------------------------------
  logic [NODE_CNT_W-1:0] n_use;
  logic                  in_acc;
  logic                  wr_in_range;
  logic                  q_in_range;
  logic [COST_WIDTH-1:0] w_in;

  // A node count of zero means one node; anything above the matrix size is
  // clamped to the matrix size.
  always_comb begin
    if (node_cnt_r == '0) begin
      n_use = NODE_CNT_W'(1);
    end else if (node_cnt_r > NODE_CNT_W'(MAX_NODES)) begin
      n_use = NODE_CNT_W'(MAX_NODES);
    end else begin
      n_use = node_cnt_r;
    end
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign cfg_ready   = 1'b1;
  assign wr_in_range = ({1'b0, in_from_node} < 7'(MAX_NODES)) &&
                       ({1'b0, in_to_node} < 7'(MAX_NODES));
  assign q_in_range  = ({1'b0, in_from_node} < n_use) && ({1'b0, in_to_node} < n_use);

  // Weights are kept in COST_WIDTH bits: truncated or zero extended.
  always_comb begin
    logic [47:0] w_ext;
    w_ext = {32'd0, in_edge_weight};
    w_in  = w_ext[COST_WIDTH-1:0];
  end

  // --------------------------------------------------------------------------
  // Relaxation stage: one matrix element per cycle. The shared adder forms
  // the candidate cost and the same stage tracks the cheapest unsettled node
  // for the next round, so no separate minimum scan is needed.
  // --------------------------------------------------------------------------
  logic [BW-1:0] cand;
  logic          upd;
  logic [BW-1:0] new_cost;
  logic          new_reach;
  logic          take;

  always_comb begin
    cand      = bp_r + BW'(edge_q[COST_WIDTH-1:0]);
    upd       = s2_vld_r && edge_q[COST_WIDTH] &&
                (!reached_r[s2_idx_r] || (cand < best_q));
    new_cost  = upd ? cand : best_q;
    new_reach = reached_r[s2_idx_r] || upd;
    take      = s2_vld_r && new_reach && !settled_r[s2_idx_r] &&
                (!min_found_r || (new_cost < min_cost_r));
  end

  // Saturated destination cost for the result.
  logic [XW-1:0] best_x;
  logic [21:0]   cost_sat;
  assign best_x   = XW'(best_q);
  assign cost_sat = (best_x > XW'(COST_OUT_MAX)) ? COST_OUT_MAX : best_x[21:0];

  logic idx_end;
  assign idx_end = ({1'b0, idx_r} == (n_use - NODE_CNT_W'(1)));

  // --------------------------------------------------------------------------
  // Sequencer: next state and datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    p_nxt         = p_r;
    bp_nxt        = bp_r;
    idx_nxt       = idx_r;
    s2_vld_nxt    = 1'b0;
    s2_idx_nxt    = idx_r;
    min_found_nxt = min_found_r;
    min_idx_nxt   = min_idx_r;
    min_cost_nxt  = min_cost_r;
    reached_nxt   = reached_r;
    settled_nxt   = settled_r;
    hops_nxt      = hops_r;
    o_node_nxt    = o_node_r;
    o_cost_nxt    = o_cost_r;
    o_reach_nxt   = o_reach_r;
    o_last_nxt    = o_last_r;

    edge_we    = 1'b0;
    edge_waddr = (AW'(in_from_node[NW-1:0]) * AW'(MAX_NODES)) + AW'(in_to_node[NW-1:0]);
    edge_wdata = {in_edge_present, w_in};
    edge_raddr = (AW'(p_r) * AW'(MAX_NODES)) + AW'(idx_r);
    best_we    = 1'b0;
    best_waddr = s2_idx_r;
    best_wdata = cand;
    best_raddr = (state_r == ST_RELAX) ? idx_r : dst_r;

    if (upd) begin
      best_we = 1'b1;
      reached_nxt[s2_idx_r] = 1'b1;
    end
    if (take) begin
      min_found_nxt = 1'b1;
      min_idx_nxt   = s2_idx_r;
      min_cost_nxt  = new_cost;
    end

    case (state_r)
      ST_CLEAR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_r;
        edge_wdata = '0;
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          src_nxt = in_from_node[NW-1:0];
          dst_nxt = in_to_node[NW-1:0];
          if (in_req_type == REQ_WRITE) begin
            edge_we = wr_in_range;
          end else if (!q_in_range) begin
            o_node_nxt  = in_to_node;
            o_cost_nxt  = '0;
            o_reach_nxt = 1'b0;
            o_last_nxt  = 1'b1;
            state_nxt   = ST_EMIT;
          end else begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        best_we       = 1'b1;
        best_waddr    = src_r;
        best_wdata    = '0;
        reached_nxt   = '0;
        settled_nxt   = '0;
        reached_nxt[src_r] = 1'b1;
        settled_nxt[src_r] = 1'b1;
        p_nxt         = src_r;
        bp_nxt        = '0;
        idx_nxt       = '0;
        min_found_nxt = 1'b0;
        state_nxt     = ST_RELAX;
      end
      ST_RELAX: begin
        s2_vld_nxt = 1'b1;
        idx_nxt    = idx_r + NW'(1);
        if (idx_end) begin
          state_nxt = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (min_found_r) begin
          p_nxt         = min_idx_r;
          bp_nxt        = min_cost_r;
          settled_nxt[min_idx_r] = 1'b1;
          idx_nxt       = '0;
          min_found_nxt = 1'b0;
          state_nxt     = ST_RELAX;
        end else begin
          state_nxt = ST_COST;
        end
      end
      ST_COST: begin
        state_nxt = ST_COST2;
      end
      ST_COST2: begin
        o_node_nxt  = 6'(dst_r);
        hops_nxt    = '0;
        if (reached_r[dst_r]) begin
          o_cost_nxt  = cost_sat;
          o_reach_nxt = 1'b1;
          o_last_nxt  = (dst_r == src_r);
        end else begin
          o_cost_nxt  = '0;
          o_reach_nxt = 1'b0;
          o_last_nxt  = 1'b1;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          state_nxt = o_last_r ? ST_IDLE : ST_PRED;
        end
      end
      ST_PRED: begin
        // The predecessor of the node just delivered is now available.
        o_node_nxt = 6'(pred_q);
        hops_nxt   = hops_r + NW'(1);
        o_last_nxt = (pred_q == src_r) || ({1'b0, hops_r} == (NW + 1)'(MAX_NODES - 2));
        state_nxt  = ST_EMIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Memory ports, read data registered
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_q <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[best_waddr] <= best_wdata;
    end
    best_q <= best_mem[best_raddr];
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      pred_mem[s2_idx_r] <= p_r;
    end
    pred_q <= pred_mem[o_node_r[NW-1:0]];
  end

  // --------------------------------------------------------------------------
  // State and control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      node_cnt_r  <= NODE_CNT_RST;
      s2_vld_r    <= 1'b0;
      min_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      s2_vld_r    <= s2_vld_nxt;
      min_found_r <= min_found_nxt;
      if (cfg_valid && cfg_ready) begin
        node_cnt_r <= cfg_data;
      end
    end
  end

  // Payload and search registers need no reset.
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    p_r        <= p_nxt;
    bp_r       <= bp_nxt;
    idx_r      <= idx_nxt;
    s2_idx_r   <= s2_idx_nxt;
    min_idx_r  <= min_idx_nxt;
    min_cost_r <= min_cost_nxt;
    reached_r  <= reached_nxt;
    settled_r  <= settled_nxt;
    hops_r     <= hops_nxt;
    o_node_r   <= o_node_nxt;
    o_cost_r   <= o_cost_nxt;
    o_reach_r  <= o_reach_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid      = (state_r == ST_EMIT);
  assign out_path_node  = o_node_r;
  assign out_total_cost = o_cost_r;
  assign out_reachable  = o_reach_r;
  assign out_last       = o_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_while_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  a_stage_in_row : assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (state_r == ST_RELAX || state_r == ST_RWAIT))
    else $error("relaxation stage active outside a row pass");

  a_unreach_single : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reachable) |-> out_last)
    else $error("unreachable result not marked final");

  a_last_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall) |=> !out_valid)
    else $error("result after the final one of a query");

endmodule

// File: bench/tb_dense_graph_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dense_graph_shortest_path: self-checking bench for the shortest path block
// Edge writes and path queries are sent through the input channel. A local
// Dijkstra search on a mirrored edge matrix predicts the hops not typed in the
// table; each accepted result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module tb_dense_graph_shortest_path
  import dgsp_pkg::*;
();

  localparam int NODES    = 64;
  localparam int WD_LIMIT = 30000;

  typedef struct {
    logic [5:0]  node;
    logic [21:0] cost;
    logic        reach;
    logic        last;
  } hop_t;

  // One row of the directed table: a register write or an input transaction,
  // with the result typed in where it is obvious at a glance.
  typedef struct {
    bit   is_cfg;
    logic req;
    int   src;
    int   dst;
    int   weight;
    bit   present;
    bit   typed;
    int   exp_node;
    bit   exp_reach;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = REQ_WRITE;
  logic [5:0]  in_from_node = '0;
  logic [5:0]  in_to_node = '0;
  logic [15:0] in_edge_weight = '0;
  logic        in_edge_present = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_path_node;
  logic [21:0] out_total_cost;
  logic        out_reachable;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  always #5 clk = ~clk;

  dense_graph_shortest_path u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_from_node(in_from_node), .in_to_node(in_to_node),
    .in_edge_weight(in_edge_weight), .in_edge_present(in_edge_present),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_path_node(out_path_node), .out_total_cost(out_total_cost),
    .out_reachable(out_reachable), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Mirror of the block's graph and its node count register.
  bit          edge_on [NODES][NODES];
  logic [15:0] edge_w  [NODES][NODES];
  int          nodes_used = NODES;

  hop_t hops_due[$];
  int   errors = 0;
  bit   calm = 0;          // no idling on either side while set
  bit   hold_req = 0;      // asks the receiver for one long hold-off
  int   quiet_cycles = 0;

  // Appends one predicted hop to the expected queue.
  task automatic enqueue_hop(input hop_t h);
    hops_due = {hops_due, h};
  endtask

  // Dijkstra over the nodes in use; the lowest index wins a tie for the next
  // node to settle, and a cost only replaces a strictly worse one.
  task automatic shortest_path(input int src, input int dst);
    longint unsigned cost_to [NODES];
    bit              seen [NODES];
    bit              done [NODES];
    int              pred [NODES];
    int              pick, node;
    longint unsigned sum;
    hop_t            h;
    if (src >= nodes_used || dst >= nodes_used) begin
      enqueue_hop('{dst[5:0], 22'd0, 1'b0, 1'b1});
      return;
    end
    for (int i = 0; i < NODES; i++) begin
      cost_to[i] = 0;
      seen[i] = 0;
      done[i] = 0;
      pred[i] = -1;
    end
    seen[src] = 1;
    for (int r = 0; r < nodes_used; r++) begin
      pick = -1;
      for (int i = 0; i < nodes_used; i++) begin
        if (seen[i] && !done[i] && (pick < 0 || cost_to[i] < cost_to[pick])) pick = i;
      end
      if (pick < 0) break;
      done[pick] = 1;
      for (int i = 0; i < nodes_used; i++) begin
        if (edge_on[pick][i]) begin
          sum = cost_to[pick] + edge_w[pick][i];
          if (!seen[i] || sum < cost_to[i]) begin
            cost_to[i] = sum;
            seen[i] = 1;
            pred[i] = pick;
          end
        end
      end
    end
    if (!seen[dst]) begin
      enqueue_hop('{dst[5:0], 22'd0, 1'b0, 1'b1});
      return;
    end
    // The path is reported from the destination back to the source.
    node = dst;
    for (int k = 0; k < NODES; k++) begin
      h.node  = node[5:0];
      h.cost  = (cost_to[dst] > COST_OUT_MAX) ? COST_OUT_MAX : cost_to[dst][21:0];
      h.reach = 1'b1;
      h.last  = (node == src) || (k == NODES - 1) || (pred[node] < 0);
      enqueue_hop(h);
      if (h.last) break;
      node = pred[node];
    end
  endtask

  // Updates the mirror for an accepted transaction and queues its results.
  task automatic take_item(input logic req, input int src, input int dst,
                           input int weight, input bit present);
    if (req == REQ_WRITE) begin
      edge_on[src][dst] = present;
      if (present) edge_w[src][dst] = weight[15:0];
    end else begin
      shortest_path(src, dst);
    end
  endtask

  // Offers one transaction, at times with a random idle gap before it outside
  // the calm phase, and returns once the block has accepted it.
  task automatic send_item(input logic req, input int src, input int dst,
                           input int weight, input bit present);
    int gap;
    if (!calm && $urandom_range(99) < 18) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_from_node    <= src[5:0];
    in_to_node      <= dst[5:0];
    in_edge_weight  <= weight[15:0];
    in_edge_present <= present;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering and waits until every queued result has come back, then
  // gives a pending edge write time to land.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hops_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_node_count(input int value);
    cfg_valid <= 1'b1;
    cfg_data  <= value[6:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    // A zero count behaves as one node, anything above the matrix as all.
    nodes_used = (value[6:0] == 0) ? 1 : (value[6:0] > NODES) ? NODES : value[6:0];
  endtask

  // Directed part: the reset node count, unreachable and trivial queries,
  // weight extremes, an equal-cost tie, edge removal, a self loop and the
  // out-of-range endpoint case after shrinking the node count.
  row_t dir_tab [] = '{
    '{0, REQ_QUERY, 0, 63, 0, 0, 1, 63, 0},
    '{0, REQ_QUERY, 5, 5, 0, 0, 1, 5, 1},
    '{0, REQ_WRITE, 0, 1, 65535, 1, 0, 0, 0},
    '{0, REQ_WRITE, 1, 63, 0, 1, 0, 0, 0},
    '{0, REQ_WRITE, 0, 63, 65535, 1, 0, 0, 0},
    '{0, REQ_QUERY, 0, 63, 0, 0, 0, 0, 0},
    '{0, REQ_WRITE, 0, 63, 16'h1234, 0, 0, 0, 0},
    '{0, REQ_QUERY, 0, 63, 0, 0, 0, 0, 0},
    '{0, REQ_WRITE, 63, 0, 16'hAAAA, 1, 0, 0, 0},
    '{0, REQ_WRITE, 62, 63, 16'h5555, 1, 0, 0, 0},
    '{0, REQ_QUERY, 63, 1, 0, 1, 0, 0, 0},
    '{0, REQ_QUERY, 1, 0, 0, 0, 0, 0, 0},
    '{0, REQ_WRITE, 0, 1, 7, 0, 0, 0, 0},
    '{0, REQ_QUERY, 0, 1, 0, 0, 1, 1, 0},
    '{0, REQ_WRITE, 7, 7, 3, 1, 0, 0, 0},
    '{0, REQ_QUERY, 7, 7, 0, 0, 1, 7, 1},
    '{1, REQ_WRITE, 2, 0, 0, 0, 0, 0, 0},
    '{0, REQ_WRITE, 1, 0, 40, 1, 0, 0, 0},
    '{0, REQ_QUERY, 1, 0, 0, 0, 0, 0, 0},
    '{0, REQ_QUERY, 0, 5, 0, 0, 1, 5, 0},
    '{0, REQ_QUERY, 63, 1, 0, 0, 1, 1, 0}
  };

  // Node count settings for the random phases, including both clamped values.
  int phase_cnt [] = '{1, 0, 5, 8, 100, 3, 127, 12, 64, 6};

  initial begin
    int   src, dst, hi;
    logic req;
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++) begin
        edge_on[i][j] = 0;
        edge_w[i][j]  = '0;
      end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].is_cfg) begin
        drain();
        write_node_count(dir_tab[r].src);
      end else begin
        send_item(dir_tab[r].req, dir_tab[r].src, dir_tab[r].dst,
                  dir_tab[r].weight, dir_tab[r].present);
        if (dir_tab[r].typed)
          enqueue_hop('{dir_tab[r].exp_node[5:0], 22'd0, dir_tab[r].exp_reach, 1'b1});
        else
          take_item(dir_tab[r].req, dir_tab[r].src, dir_tab[r].dst,
                    dir_tab[r].weight, dir_tab[r].present);
      end
    end

    foreach (phase_cnt[p]) begin
      drain();
      write_node_count(phase_cnt[p]);
      calm = (p == 3);
      if (p == 2) hold_req = 1;
      for (int k = 0; k < 10; k++) begin
        hi  = nodes_used - 1;
        req = ($urandom_range(99) < 30) ? REQ_QUERY : REQ_WRITE;
        // Mostly endpoints among the nodes in use, some anywhere in the matrix.
        if ($urandom_range(99) < 80) begin
          src = $urandom_range(hi);
          dst = $urandom_range(hi);
        end else begin
          src = $urandom_range(63);
          dst = $urandom_range(63);
        end
        send_item(req, src, dst, $urandom_range(16'hFFFF), $urandom_range(99) < 85);
        take_item(in_req_type, src, dst, in_edge_weight, in_edge_present);
      end
    end
    calm = 0;

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("PASS dense_graph_shortest_path");
    else
      $display("FAIL dense_graph_shortest_path");
    $finish;
  end

  // Receiver: random stalls, none during the calm phase, and one long
  // hold-off so that pending results back up into the input channel.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 18);
      end
    end
  end

  // Result checker: every completed output transaction is matched against the
  // oldest predicted hop.
  always @(posedge clk) begin
    hop_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hops_due.size() == 0) begin
        $display("%0t: unexpected result node %0d cost %0d", $time,
                 out_path_node, out_total_cost);
        errors++;
      end else begin
        want = hops_due.pop_front();
        if (out_path_node !== want.node) begin
          $display("%0t: path_node expected %0d actual %0d", $time, want.node,
                   out_path_node);
          errors++;
        end
        if (out_total_cost !== want.cost) begin
          $display("%0t: total_cost expected %0d actual %0d", $time, want.cost,
                   out_total_cost);
          errors++;
        end
        if (out_reachable !== want.reach) begin
          $display("%0t: reachable expected %0b actual %0b", $time, want.reach,
                   out_reachable);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on any channel means
  // the block has hung. The limit covers the clearing pass after reset, a
  // full-size search and the long receiver hold-off with margin.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WD_LIMIT);
      $display("FAIL dense_graph_shortest_path");
      $finish;
    end
  end

endmodule

// File: dense_graph_shortest_path.f
rtl/dgsp_pkg.sv
rtl/dense_graph_shortest_path.sv
bench/tb_dense_graph_shortest_path.sv
